FILE: design/bmt_pkg.sv
// Shared types, codes and sizing constants for the breakpoint match table.
package bmt_pkg;

  localparam int ADDR_W      = 32;
  localparam int IDX_W       = 4;
  localparam int CNT_OUT_W   = 5;
  localparam int ENTRIES_DEF = 16;
  localparam int MAX_ENTRIES = 256;
  localparam int POS_W       = $clog2(MAX_ENTRIES);
  localparam int GROUP       = 16;

  typedef logic [POS_W-1:0] pos_t;

  typedef enum logic [3:0] {
    CMD_SET         = 4'd0,
    CMD_UNSET       = 4'd1,
    CMD_TOGGLE      = 4'd2,
    CMD_ENABLE_AT   = 4'd3,
    CMD_DISABLE_AT  = 4'd4,
    CMD_BREAK_CHECK = 4'd5,
    CMD_CLEAR       = 4'd6,
    CMD_CLEAR_TEMP  = 4'd7,
    CMD_ENABLE_IDX  = 4'd8,
    CMD_DISABLE_IDX = 4'd9,
    CMD_REMOVE_IDX  = 4'd10,
    CMD_READ_IDX    = 4'd11,
    CMD_HAS         = 4'd12,
    CMD_HAS_STATE   = 4'd13
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DISABLED  = 2'd0,
    ST_ENABLED   = 2'd1,
    ST_TEMPORARY = 2'd2
  } bp_state_t;

  typedef enum logic [1:0] {
    RES_DONE     = 2'd0,
    RES_NOCHANGE = 2'd1,
    RES_FULL     = 2'd2,
    RES_BADINDEX = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RED_A,
    S_RED_B,
    S_APPLY,
    S_COMPACT
  } fsm_t;

  // lookup request broadcast to every cell on the accept cycle
  typedef struct packed {
    logic                capture;
    logic                by_index;
    logic [ADDR_W-1:0]   address;
    logic [IDX_W-1:0]    index;
  } sel_req_t;

  // table update broadcast to every cell
  typedef struct packed {
    logic                load_en;
    logic                state_only;
    pos_t                load_pos;
    logic [ADDR_W-1:0]   load_addr;
    logic [1:0]          load_state;
    logic                shift_en;
    pos_t                shift_pos;
  } cell_upd_t;

endpackage

FILE: design/bmt_if.sv
// Valid/ready channel interfaces for command words and result words.
interface bmt_in_if import bmt_pkg::*;;
  logic                valid;
  logic                ready;
  logic [3:0]          command;
  logic [ADDR_W-1:0]   address;
  logic [1:0]          bp_state;
  logic [IDX_W-1:0]    entry_index;

  modport source (output valid, command, address, bp_state, entry_index, input ready);
  modport sink   (input valid, command, address, bp_state, entry_index, output ready);
endinterface

interface bmt_out_if import bmt_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [1:0]           status;
  logic [ADDR_W-1:0]    read_address;
  logic [1:0]           read_state;
  logic [CNT_OUT_W-1:0] entry_count;

  modport source (output valid, hit, status, read_address, read_state, entry_count,
                  input ready);
  modport sink   (input valid, hit, status, read_address, read_state, entry_count,
                  output ready);
endinterface

FILE: design/breakpoint_match_table.sv
// Top level of the breakpoint match table: cell row, reduction and command sequencer.
//
//  channel | dir | handshake     | word
//  --------+-----+---------------+--------------------------------------------------
//  in_ch   | in  | valid/ready   | command, address, bp_state, entry_index
//  out_ch  | out | valid/ready   | hit, status, read_address, read_state, entry_count
//
// An item passes through accept (every cell compares its entry), two stages of
// the OR tree that collects match flag, position and data, then apply.
// clear_temp adds a compaction pass before it writes its result: the
// row rotates through cell 0 and kept entries are appended at the tail.
// Reset empties the table (count to zero); entries need no clearing pass.
// A result waiting in the output register holds the apply step; the next
// command is taken as soon as the previous one has written its result.
module breakpoint_match_table import bmt_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  bmt_in_if.sink           in_ch,
  bmt_out_if.source        out_ch
);

  localparam int CW = $clog2(ENTRIES+1);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int LW = 1 + IW + ADDR_W + 2;

  // current command word
  cmd_t               cmd_r;
  logic [1:0]         st_r;
  logic [ADDR_W-1:0]  cmd_addr_r;

  fsm_t               state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      steps_r, steps_nxt;

  logic               out_valid_r;
  logic               out_hit_r;
  logic [1:0]         out_status_r;
  logic [ADDR_W-1:0]  out_raddr_r;
  logic [1:0]         out_rstate_r;
  logic [CNT_OUT_W-1:0] out_count_r;

  logic               res_wr;
  logic               res_hit;
  status_t            res_status;
  logic [ADDR_W-1:0]  res_raddr;
  logic [1:0]         res_rstate;

  logic               accept;
  logic               out_free;
  logic               full;

  sel_req_t           req;
  cell_upd_t          upd;

  logic [ENTRIES-1:0][ADDR_W-1:0] c_addr;
  logic [ENTRIES-1:0][1:0]        c_state;
  logic [ENTRIES-1:0][ADDR_W-1:0] nb_addr;
  logic [ENTRIES-1:0][1:0]        nb_state;
  logic [ENTRIES-1:0][LW-1:0]     lanes;
  logic [LW-1:0]                  red;

  logic               r_any;
  logic [IW-1:0]      r_pos;
  logic [ADDR_W-1:0]  r_addr;
  logic [1:0]         r_state;
  logic               keep;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign full        = (count_r == CW'(ENTRIES));

  // lookup request goes straight from the input word to the cells
  always_comb begin
    req.capture  = accept;
    req.by_index = in_ch.command inside {CMD_ENABLE_IDX, CMD_DISABLE_IDX,
                                         CMD_REMOVE_IDX, CMD_READ_IDX};
    req.address  = in_ch.address;
    req.index    = in_ch.entry_index;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r      <= cmd_t'(in_ch.command);
      st_r       <= in_ch.bp_state;
      cmd_addr_r <= in_ch.address;
    end
  end

  // row of cells; each takes the entry of its right neighbor on a shift, the last its own
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    if (i < ENTRIES - 1) begin : g_nb
      assign nb_addr[i]  = c_addr[i+1];
      assign nb_state[i] = c_state[i+1];
    end else begin : g_tail
      assign nb_addr[i]  = c_addr[i];
      assign nb_state[i] = c_state[i];
    end

    bmt_cell #(
      .ENTRIES (ENTRIES),
      .IDX     (i)
    ) u_cell (
      .clk      (clk),
      .req      (req),
      .count    (count_r),
      .upd      (upd),
      .nb_addr  (nb_addr[i]),
      .nb_state (nb_state[i]),
      .addr_o   (c_addr[i]),
      .state_o  (c_state[i]),
      .lane     (lanes[i])
    );
  end

  bmt_or_tree #(
    .ENTRIES (ENTRIES),
    .W       (LW)
  ) u_tree (
    .clk    (clk),
    .lanes  (lanes),
    .result (red)
  );

  // addresses are unique in the table, so at most one lane is set
  assign r_any   = red[LW-1];
  assign r_pos   = red[LW-2 -: IW];
  assign r_addr  = red[ADDR_W+1:2];
  assign r_state = red[1:0];

  assign keep = (c_state[0] != ST_TEMPORARY);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    if (accept) state_nxt = S_RED_A;
      S_RED_A:   state_nxt = S_RED_B;
      S_RED_B:   state_nxt = S_APPLY;
      S_APPLY: begin
        if (cmd_r == CMD_CLEAR_TEMP) begin
          state_nxt = S_COMPACT;
        end else if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_COMPACT: if ((steps_r == '0) && out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // table update and result
  always_comb begin
    upd        = '0;
    res_wr     = 1'b0;
    res_hit    = 1'b0;
    res_status = RES_DONE;
    res_raddr  = '0;
    res_rstate = '0;
    count_nxt  = count_r;
    steps_nxt  = steps_r;
    case (state_r)
      S_APPLY: begin
        if (cmd_r == CMD_CLEAR_TEMP) begin
          steps_nxt = count_r;
        end else if (out_free) begin
          res_wr = 1'b1;
          case (cmd_r)
            CMD_SET: begin
              if (!(st_r inside {ST_DISABLED, ST_ENABLED, ST_TEMPORARY}) || r_any) begin
                res_status = RES_NOCHANGE;
              end else if (full) begin
                res_status = RES_FULL;
              end else begin
                upd.load_en    = 1'b1;
                upd.load_pos   = POS_W'(count_r);
                upd.load_addr  = cmd_addr_r;
                upd.load_state = st_r;
                count_nxt      = count_r + CW'(1);
              end
            end
            CMD_UNSET, CMD_REMOVE_IDX: begin
              if (r_any) begin
                upd.shift_en  = 1'b1;
                upd.shift_pos = POS_W'(r_pos);
                count_nxt     = count_r - CW'(1);
              end else begin
                res_status = (cmd_r == CMD_UNSET) ? RES_NOCHANGE : RES_BADINDEX;
              end
            end
            CMD_TOGGLE: begin
              if (r_any && (r_state == ST_ENABLED)) begin
                upd.shift_en  = 1'b1;
                upd.shift_pos = POS_W'(r_pos);
                count_nxt     = count_r - CW'(1);
              end else if (r_any && (r_state == ST_DISABLED)) begin
                upd.load_en    = 1'b1;
                upd.state_only = 1'b1;
                upd.load_pos   = POS_W'(r_pos);
                upd.load_state = ST_ENABLED;
              end else if (r_any) begin
                res_status = RES_NOCHANGE;
              end else if (full) begin
                res_status = RES_FULL;
              end else begin
                upd.load_en    = 1'b1;
                upd.load_pos   = POS_W'(count_r);
                upd.load_addr  = cmd_addr_r;
                upd.load_state = ST_ENABLED;
                count_nxt      = count_r + CW'(1);
              end
            end
            CMD_ENABLE_AT, CMD_DISABLE_AT, CMD_ENABLE_IDX, CMD_DISABLE_IDX: begin
              if (r_any) begin
                upd.load_en    = 1'b1;
                upd.state_only = 1'b1;
                upd.load_pos   = POS_W'(r_pos);
                upd.load_state = (cmd_r == CMD_ENABLE_AT || cmd_r == CMD_ENABLE_IDX) ?
                                 ST_ENABLED : ST_DISABLED;
              end else begin
                res_status = (cmd_r == CMD_ENABLE_AT || cmd_r == CMD_DISABLE_AT) ?
                             RES_NOCHANGE : RES_BADINDEX;
              end
            end
            CMD_BREAK_CHECK: begin
              if (r_any && (r_state != ST_DISABLED)) begin
                res_hit = 1'b1;
                // drop a temporary breakpoint once it fires
                if (r_state == ST_TEMPORARY) begin
                  upd.shift_en  = 1'b1;
                  upd.shift_pos = POS_W'(r_pos);
                  count_nxt     = count_r - CW'(1);
                end
              end else begin
                res_status = RES_NOCHANGE;
              end
            end
            CMD_CLEAR: count_nxt = '0;
            CMD_READ_IDX: begin
              if (r_any) begin
                res_raddr  = r_addr;
                res_rstate = r_state;
              end else begin
                res_status = RES_BADINDEX;
              end
            end
            CMD_HAS:       res_hit = r_any;
            CMD_HAS_STATE: res_hit = r_any && (r_state == st_r);
            default:       res_status = RES_NOCHANGE;
          endcase
        end
      end
      S_COMPACT: begin
        if (steps_r != '0) begin
          // pop the head, append it at the tail if it stays
          upd.shift_en   = 1'b1;
          upd.shift_pos  = '0;
          upd.load_en    = keep;
          upd.load_pos   = POS_W'(count_r - CW'(1));
          upd.load_addr  = c_addr[0];
          upd.load_state = c_state[0];
          count_nxt      = keep ? count_r : count_r - CW'(1);
          steps_nxt      = steps_r - CW'(1);
        end else if (out_free) begin
          res_wr = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      steps_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      steps_r     <= steps_nxt;
      out_valid_r <= res_wr || (out_valid_r && !out_ch.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (res_wr) begin
      out_hit_r    <= res_hit;
      out_status_r <= res_status;
      out_raddr_r  <= res_raddr;
      out_rstate_r <= res_rstate;
      out_count_r  <= CNT_OUT_W'(count_nxt);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.hit          = out_hit_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.read_address = out_raddr_r;
  assign out_ch.read_state   = out_rstate_r;
  assign out_ch.entry_count  = out_count_r;

  // the table never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(ENTRIES))
    else $error("entry count above table depth");

  // a result word only comes out of apply or the end of compaction
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_APPLY || $past(state_r) == S_COMPACT))
    else $error("result word raised outside apply");

  // compaction only ever shrinks the table
  a_compact_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMPACT) |=> (count_r <= $past(count_r)))
    else $error("compaction grew the table");

endmodule

FILE: design/bmt_cell.sv
// One table position: stored entry, lookup compare and shift toward the head.
module bmt_cell import bmt_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int IDX     = 0
) (
  input  logic                      clk,
  input  sel_req_t                  req,
  input  logic [$clog2(ENTRIES+1)-1:0] count,
  input  cell_upd_t                 upd,
  input  logic [ADDR_W-1:0]         nb_addr,
  input  logic [1:0]                nb_state,
  output logic [ADDR_W-1:0]         addr_o,
  output logic [1:0]                state_o,
  output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)+ADDR_W+2:0] lane
);

  localparam int CW = $clog2(ENTRIES+1);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [ADDR_W-1:0] addr_r;
  logic [1:0]        state_r;
  logic              sel_r;
  logic              sel_nxt;
  logic              occupied;

  assign occupied = count > CW'(IDX);

  always_comb begin
    if (req.by_index) begin
      sel_nxt = occupied && ({{(32-IDX_W){1'b0}}, req.index} == 32'(IDX));
    end else begin
      sel_nxt = occupied && (addr_r == req.address);
    end
  end

  always_ff @(posedge clk) begin
    if (req.capture) begin
      sel_r <= sel_nxt;
    end
    // load wins over shift so a compaction step can append at the tail
    if (upd.load_en && (upd.load_pos == POS_W'(IDX))) begin
      if (!upd.state_only) begin
        addr_r <= upd.load_addr;
      end
      state_r <= upd.load_state;
    end else if (upd.shift_en && (POS_W'(IDX) >= upd.shift_pos)) begin
      addr_r  <= nb_addr;
      state_r <= nb_state;
    end
  end

  assign addr_o  = addr_r;
  assign state_o = state_r;
  assign lane    = sel_r ? {1'b1, IW'(IDX), addr_r, state_r} : '0;

endmodule

FILE: design/bmt_or_tree.sv
// Two-stage registered OR reduction over the cell lanes.
module bmt_or_tree import bmt_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int W       = 1
) (
  input  logic                       clk,
  input  logic [ENTRIES-1:0][W-1:0]  lanes,
  output logic [W-1:0]               result
);

  localparam int NG = (ENTRIES + GROUP - 1) / GROUP;

  logic [NG-1:0][W-1:0] grp_r;
  logic [NG-1:0][W-1:0] grp_nxt;
  logic [W-1:0]         sum_r;
  logic [W-1:0]         sum_nxt;

  always_comb begin
    grp_nxt = '0;
    for (int g = 0; g < NG; g++) begin
      for (int j = 0; j < GROUP; j++) begin
        if (g * GROUP + j < ENTRIES) begin
          grp_nxt[g] = grp_nxt[g] | lanes[g * GROUP + j];
        end
      end
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int g = 0; g < NG; g++) begin
      sum_nxt = sum_nxt | grp_r[g];
    end
  end

  always_ff @(posedge clk) begin
    grp_r <= grp_nxt;
    sum_r <= sum_nxt;
  end

  assign result = sum_r;

endmodule

FILE: tb/bmt_checker.sv
// Checker for the breakpoint match table: predicts every result word and compares it.
module bmt_checker import bmt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  bmt_in_if    in_ch,
  bmt_out_if   out_ch,
  output int   mismatch_count,
  output int   results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PRINT_CAP = 50;

  typedef struct {
    logic                 hit;
    logic [1:0]           status;
    logic [ADDR_W-1:0]    rd_addr;
    logic [1:0]           rd_state;
    logic [CNT_OUT_W-1:0] count;
  } bp_answer_t;

  bp_answer_t        answer_q[$];
  logic [ADDR_W-1:0] slot_addr [ENTRIES_DEF];
  bp_state_t         slot_state[ENTRIES_DEF];
  int                live;

  initial begin
    mismatch_count = 0;
    results_pending = 0;
    live = 0;
  end

  function automatic bit holds_addr(logic [ADDR_W-1:0] a);
    for (int p = 0; p < live; p++)
      if (slot_addr[p] == a) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit holds_addr_state(logic [ADDR_W-1:0] a, logic [1:0] s);
    for (int p = 0; p < live; p++)
      if (slot_addr[p] == a && slot_state[p] == s) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void drop_slot(int pos);
    for (int p = pos; p + 1 < live; p++) begin
      slot_addr[p] = slot_addr[p + 1];
      slot_state[p] = slot_state[p + 1];
    end
    live--;
  endfunction

  // keep order, squeeze out either the matching address or every temporary entry
  function automatic int squeeze(bit by_temp, logic [ADDR_W-1:0] a);
    int w;
    int removed;
    bit drop;
    w = 0;
    removed = 0;
    for (int p = 0; p < live; p++) begin
      drop = by_temp ? (slot_state[p] == ST_TEMPORARY) : (slot_addr[p] == a);
      if (drop) begin
        removed++;
      end else begin
        slot_addr[w] = slot_addr[p];
        slot_state[w] = slot_state[p];
        w++;
      end
    end
    live = w;
    return removed;
  endfunction

  function automatic status_t add_entry(logic [ADDR_W-1:0] a, logic [1:0] s);
    if (s > ST_TEMPORARY || holds_addr(a)) return RES_NOCHANGE;
    if (live >= ENTRIES_DEF) return RES_FULL;
    slot_addr[live] = a;
    slot_state[live] = bp_state_t'(s);
    live++;
    return RES_DONE;
  endfunction

  function automatic status_t drop_addr(logic [ADDR_W-1:0] a);
    return (squeeze(1'b0, a) != 0) ? RES_DONE : RES_NOCHANGE;
  endfunction

  function automatic status_t restate_addr(logic [ADDR_W-1:0] a, bp_state_t s);
    bit any;
    any = 1'b0;
    for (int p = 0; p < live; p++) begin
      if (slot_addr[p] == a) begin
        slot_state[p] = s;
        any = 1'b1;
      end
    end
    return any ? RES_DONE : RES_NOCHANGE;
  endfunction

  function automatic bp_answer_t predict_answer(logic [3:0] c, logic [ADDR_W-1:0] a,
                                                logic [1:0] s, logic [IDX_W-1:0] i);
    bp_answer_t r;
    r = '{default: '0};
    r.status = RES_DONE;
    case (c)
      CMD_SET:        r.status = add_entry(a, s);
      CMD_UNSET:      r.status = drop_addr(a);
      CMD_TOGGLE: begin
        if (holds_addr_state(a, ST_ENABLED)) r.status = drop_addr(a);
        else if (holds_addr_state(a, ST_DISABLED)) r.status = restate_addr(a, ST_ENABLED);
        else r.status = add_entry(a, ST_ENABLED);
      end
      CMD_ENABLE_AT:  r.status = restate_addr(a, ST_ENABLED);
      CMD_DISABLE_AT: r.status = restate_addr(a, ST_DISABLED);
      CMD_BREAK_CHECK: begin
        r.status = RES_NOCHANGE;
        for (int p = 0; p < live; p++) begin
          if (slot_addr[p] == a && slot_state[p] != ST_DISABLED) begin
            r.hit = 1'b1;
            r.status = RES_DONE;
            if (slot_state[p] == ST_TEMPORARY) drop_slot(p);
            break;
          end
        end
      end
      CMD_CLEAR:      live = 0;
      CMD_CLEAR_TEMP: void'(squeeze(1'b1, '0));
      CMD_ENABLE_IDX, CMD_DISABLE_IDX, CMD_REMOVE_IDX, CMD_READ_IDX: begin
        if (int'(i) >= live) begin
          r.status = RES_BADINDEX;
        end else begin
          case (c)
            CMD_ENABLE_IDX:  slot_state[i] = ST_ENABLED;
            CMD_DISABLE_IDX: slot_state[i] = ST_DISABLED;
            CMD_REMOVE_IDX:  drop_slot(int'(i));
            default: begin
              r.rd_addr = slot_addr[i];
              r.rd_state = slot_state[i];
            end
          endcase
        end
      end
      CMD_HAS:        r.hit = holds_addr(a);
      CMD_HAS_STATE:  r.hit = holds_addr_state(a, s);
      default:        r.status = RES_NOCHANGE;
    endcase
    r.count = CNT_OUT_W'(live);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [ADDR_W-1:0] got, logic [ADDR_W-1:0] want);
    if (mismatch_count < PRINT_CAP)
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    bp_answer_t want;
    if (!rst_n) begin
      answer_q.delete();
      live = 0;
      results_pending <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (answer_q.size() == 0) begin
          report_mismatch("result word with nothing outstanding",
                          ADDR_W'(out_ch.status), '0);
        end else begin
          want = answer_q.pop_front();
          if (out_ch.hit !== want.hit)
            report_mismatch("hit", ADDR_W'(out_ch.hit), ADDR_W'(want.hit));
          if (out_ch.status !== want.status)
            report_mismatch("status", ADDR_W'(out_ch.status), ADDR_W'(want.status));
          if (out_ch.read_address !== want.rd_addr)
            report_mismatch("read_address", out_ch.read_address, want.rd_addr);
          if (out_ch.read_state !== want.rd_state)
            report_mismatch("read_state", ADDR_W'(out_ch.read_state),
                            ADDR_W'(want.rd_state));
          if (out_ch.entry_count !== want.count)
            report_mismatch("entry_count", ADDR_W'(out_ch.entry_count),
                            ADDR_W'(want.count));
        end
      end
      if (in_ch.valid && in_ch.ready)
        answer_q.insert(answer_q.size(),
                        predict_answer(in_ch.command, in_ch.address, in_ch.bp_state,
                                       in_ch.entry_index));
      results_pending <= answer_q.size();
    end
  end

endmodule

FILE: tb/breakpoint_match_table_test.sv
// Top of the breakpoint match table testbench: clock, reset, command stimulus and verdict.
module breakpoint_match_table_test import bmt_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // cycles with no word moving on either channel before the run is declared hung
  localparam int IDLE_LIMIT       = 1000;
  // longest single command is clear_temp on a full table, which steps through every entry
  localparam int SETTLE_CYCLES    = 40;
  localparam int RANDOM_PER_PHASE = 400;
  localparam int HOT_COUNT        = 20;
  localparam int EPISODE_LEN      = 50;

  logic clk;
  logic rst_n;
  int   fail_total;
  int   pending;
  int   idle_run;
  int   send_idle_pct;
  int   recv_stall_pct;
  logic [ADDR_W-1:0] hot_addr[HOT_COUNT];

  bmt_in_if  in_ch();
  bmt_out_if out_ch();

  breakpoint_match_table #(.ENTRIES(ENTRIES_DEF)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  bmt_checker CHECK (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .mismatch_count  (fail_total),
    .results_pending (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Result side: drop ready at random, at the rate set for the current phase.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: count cycles in which no word moves; give up at the limit.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_run <= 0;
    end else if (idle_run >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  // Drive one command word. Enter at a falling edge; leave at the falling edge
  // after the word was taken. While the sender idles, hold valid low and
  // scramble the payload so a block that latches idle words is caught.
  // Ready only moves at a rising edge, so its value at a falling edge tells
  // whether the word goes in at the next rising edge.
  task automatic send_word(input logic [3:0] c, input logic [ADDR_W-1:0] a,
                           input logic [1:0] s, input logic [IDX_W-1:0] i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid       <= 1'b0;
      in_ch.command     <= 4'($urandom);
      in_ch.address     <= $urandom;
      in_ch.bp_state    <= 2'($urandom);
      in_ch.entry_index <= 4'($urandom);
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.command     <= c;
    in_ch.address     <= a;
    in_ch.bp_state    <= s;
    in_ch.entry_index <= i;
    while (!in_ch.ready) @(negedge clk);
    @(negedge clk);
  endtask

  // Random command word. Growth episodes lean on set with addresses from a small
  // pool so the table fills up and hits are common; the rest is a broad mix.
  task automatic send_random(input bit grow);
    logic [3:0]        c;
    logic [ADDR_W-1:0] a;
    logic [1:0]        s;
    int                roll;
    roll = $urandom_range(99);
    if (grow && roll < 50) begin
      c = CMD_SET;
    end else if (roll < 53) begin
      c = 4'(14 + $urandom_range(1));
    end else begin
      c = 4'($urandom_range(CMD_HAS_STATE));
      // keep clear rare so the table gets deep
      if (c == CMD_CLEAR && $urandom_range(3) != 0) c = CMD_SET;
    end
    a = ($urandom_range(3) == 0) ? $urandom : hot_addr[$urandom_range(HOT_COUNT - 1)];
    s = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(ST_TEMPORARY));
    send_word(c, a, s, 4'($urandom));
  endtask

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.command     = '0;
    in_ch.address     = '0;
    in_ch.bp_state    = '0;
    in_ch.entry_index = '0;
    out_ch.ready      = 1'b0;
    idle_run          = 0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    foreach (hot_addr[k]) hot_addr[k] = $urandom;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed words, no idling: empty-table index errors, duplicates,
    // bad state value, toggle add, remove and no-change paths, temporary removal on a hit,
    // disabled entries that never break, index commands, unused codes.
    send_word(CMD_READ_IDX,    '0,           ST_DISABLED,  4'd0);
    send_word(CMD_REMOVE_IDX,  '0,           ST_DISABLED,  4'd15);
    send_word(CMD_SET,         32'h0,        ST_ENABLED,   4'd0);
    send_word(CMD_SET,         32'hFFFFFFFF, ST_TEMPORARY, 4'd0);
    send_word(CMD_SET,         32'hFFFFFFFF, ST_DISABLED,  4'd0);
    send_word(CMD_SET,         32'h12345678, 2'd3,         4'd0);
    send_word(CMD_HAS,         32'h0,        ST_DISABLED,  4'd0);
    send_word(CMD_HAS_STATE,   32'hFFFFFFFF, ST_TEMPORARY, 4'd0);
    send_word(CMD_HAS_STATE,   32'hFFFFFFFF, 2'd3,         4'd0);
    send_word(CMD_TOGGLE,      32'h0,        ST_DISABLED,  4'd0);
    send_word(CMD_TOGGLE,      32'h0,        ST_DISABLED,  4'd0);
    send_word(CMD_DISABLE_AT,  32'h0,        ST_DISABLED,  4'd0);
    send_word(CMD_TOGGLE,      32'h0,        ST_DISABLED,  4'd0);
    send_word(CMD_TOGGLE,      32'hFFFFFFFF, ST_DISABLED,  4'd0);
    send_word(CMD_BREAK_CHECK, 32'hFFFFFFFF, ST_DISABLED,  4'd0);
    send_word(CMD_BREAK_CHECK, 32'hFFFFFFFF, ST_DISABLED,  4'd0);
    send_word(CMD_ENABLE_AT,   32'h00000055, ST_DISABLED,  4'd0);
    send_word(CMD_SET,         32'hA5A5A5A5, ST_DISABLED,  4'd0);
    send_word(CMD_BREAK_CHECK, 32'hA5A5A5A5, ST_DISABLED,  4'd0);
    send_word(CMD_READ_IDX,    '0,           ST_DISABLED,  4'd1);
    send_word(CMD_ENABLE_IDX,  '0,           ST_DISABLED,  4'd1);
    send_word(CMD_DISABLE_IDX, '0,           ST_DISABLED,  4'd0);
    send_word(CMD_REMOVE_IDX,  '0,           ST_DISABLED,  4'd0);
    send_word(CMD_SET,         32'h5A5A5A5A, ST_TEMPORARY, 4'd0);
    send_word(CMD_CLEAR_TEMP,  '0,           ST_DISABLED,  4'd0);
    send_word(4'd14,           '0,           ST_DISABLED,  4'd0);
    send_word(4'd15,           '0,           ST_DISABLED,  4'd0);
    send_word(CMD_CLEAR,       '0,           ST_DISABLED,  4'd0);

    // Random words in four phases: no idling, a mostly idle sender,
    // a mostly stalling receiver, and light idling on both sides.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++)
        send_random(((n / EPISODE_LEN) % 2) == 0);
    end
    in_ch.valid <= 1'b0;

    // Drain: wait for every outstanding result, then let the block settle.
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_total == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
